// ----- rtl/core/wfba_pkg.sv -----
// Shared types and constants for the worst-fit block allocator.
// No dependencies; the allocator top level and the testbench refer to it by scoped names.
package wfba_pkg;

   // Field widths of the request and response words.
   localparam int MODE_W      = 1;
   localparam int REQ_IDX_W   = 4;
   localparam int REQ_SIZE_W  = 16;
   localparam int TOTAL_W     = 32;
   localparam int CSR_W       = 5;

   // Request word operation codes.
   localparam logic [MODE_W-1:0] MODE_LOAD    = 1'b0;
   localparam logic [MODE_W-1:0] MODE_REQUEST = 1'b1;

   // Saturation value of both totals.
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE
   } wfba_state_type;

endpackage

// ----- rtl/core/wfba_table.sv -----
// Free-size table: one write port and one read port with registered read data.
// Depends on nothing; instantiated by the allocator top level.
module wfba_table #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 16,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/wfba_fit_unit.sv -----
// Shared subtract-and-compare unit that keeps the best candidate of one scan.
// Depends on nothing; driven one table entry per cycle by the allocator sequencer.
module wfba_fit_unit #(
   parameter int SIZE_BITS = 16,
   parameter int IDX_W     = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic                 valid,
   input  logic [SIZE_BITS-1:0] free_size,
   input  logic [IDX_W-1:0]     entry_idx,
   input  logic [SIZE_BITS-1:0] req_size,
   output logic                 found,
   output logic [IDX_W-1:0]     best_idx,
   output logic [SIZE_BITS-1:0] best_left
);

   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [SIZE_BITS-1:0] best_left_ff, best_left_in;
   logic [SIZE_BITS:0]   diff;
   logic                 fits;
   logic                 better;

   // The borrow out of the subtraction tells whether the entry can hold the request.
   assign diff   = {1'b0, free_size} - {1'b0, req_size};
   assign fits   = ~diff[SIZE_BITS];
   assign better = fits && (!found_ff || (diff[SIZE_BITS-1:0] > best_left_ff));

   always_comb begin
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_left_in = best_left_ff;
      if (clear) begin
         found_in = 1'b0;
      end else if (valid && better) begin
         found_in     = 1'b1;
         best_idx_in  = entry_idx;
         best_left_in = diff[SIZE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      best_idx_ff  <= best_idx_in;
      best_left_ff <= best_left_in;
   end

   assign found     = found_ff;
   assign best_idx  = best_idx_ff;
   assign best_left = best_left_ff;

endmodule

// ----- rtl/core/worst_fit_block_allocator.sv -----
// Top level of the worst-fit block allocator: sequencer, totals and response register.
// Depends on wfba_pkg, wfba_table and wfba_fit_unit.
//
// Usage:
// A request word is taken at a rising edge where start is high and busy is low.
// A load word (mode 0) writes one table entry in that same cycle and leaves busy
// low, so loads can be issued back to back; a load to an index past the table
// is dropped and no response is produced for any load.
// A request word (mode 1) raises busy and reads entries 0 .. limit-1 one per
// cycle through the single table read port, where limit is blocks_in_use
// clamped to NUM_BLOCKS. One shared subtract-and-compare unit judges each entry.
// A request holds busy through the scan, while the last read travels to the compare
// unit, and through the write-back state. The response word is shown on the rsp_
// ports with rsp_valid high for exactly one cycle, starting at the edge where
// busy falls again. The receiver cannot stall, so the response is never held.
// blocks_in_use is written through csr_wr_en/csr_wr_data; the user must write it
// only while the block is idle, and the block itself does not enforce this.
// Reset clears the sequencer, both totals and blocks_in_use; the table contents
// are undefined until loaded.
module worst_fit_block_allocator #(
   parameter int NUM_BLOCKS = 16,
   parameter int SIZE_BITS  = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [wfba_pkg::MODE_W-1:0]         req_mode,
   input  logic [wfba_pkg::REQ_IDX_W-1:0]      req_block_index,
   input  logic [wfba_pkg::REQ_SIZE_W-1:0]     req_size,
   output logic                                rsp_valid,
   output logic                                rsp_granted,
   output logic [wfba_pkg::REQ_IDX_W-1:0]      rsp_chosen_block,
   output logic [wfba_pkg::TOTAL_W-1:0]        rsp_internal_total,
   output logic [wfba_pkg::TOTAL_W-1:0]        rsp_external_total,
   input  logic                                csr_wr_en,
   input  logic [wfba_pkg::CSR_W-1:0]          csr_wr_data
);

   localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

   wfba_pkg::wfba_state_type state_ff, state_in;

   logic [wfba_pkg::CSR_W-1:0]   blocks_in_use_ff, blocks_in_use_in;
   logic [CNT_W-1:0]             limit_ff, limit_in;
   logic [CNT_W-1:0]             addr_ff, addr_in;
   logic                         pend_ff, pend_in;
   logic [IDX_W-1:0]             cmp_idx_ff, cmp_idx_in;
   logic [SIZE_BITS-1:0]         size_ff, size_in;
   logic [wfba_pkg::TOTAL_W-1:0] int_sum_ff, int_sum_in;
   logic [wfba_pkg::TOTAL_W-1:0] ext_sum_ff, ext_sum_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_granted_ff, rsp_granted_in;
   logic [wfba_pkg::REQ_IDX_W-1:0] rsp_chosen_ff, rsp_chosen_in;

   logic                 accept;
   logic                 load_hit;
   logic [CNT_W-1:0]     limit_clamped;
   logic                 rd_en;
   logic                 fit_clear;
   logic                 tbl_wr_en;
   logic [IDX_W-1:0]     tbl_wr_addr;
   logic [SIZE_BITS-1:0] tbl_wr_data;
   logic [SIZE_BITS-1:0] tbl_rd_data;
   logic [SIZE_BITS-1:0] req_size_cut;
   logic                 fit_found;
   logic [IDX_W-1:0]     fit_best_idx;
   logic [SIZE_BITS-1:0] fit_best_left;
   logic [wfba_pkg::TOTAL_W:0] sum_add;
   logic [wfba_pkg::TOTAL_W-1:0] sum_sat;

   assign accept       = start && !busy;
   assign req_size_cut = SIZE_BITS'(req_size);
   assign load_hit     = accept && (req_mode == wfba_pkg::MODE_LOAD) &&
                         (32'(req_block_index) < 32'(NUM_BLOCKS));
   assign limit_clamped = (32'(blocks_in_use_ff) > 32'(NUM_BLOCKS)) ?
                          CNT_W'(NUM_BLOCKS) : CNT_W'(blocks_in_use_ff);
   assign rd_en = (state_ff == wfba_pkg::ST_SCAN) && (addr_ff < limit_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wfba_pkg::ST_IDLE: begin
            if (accept && (req_mode == wfba_pkg::MODE_REQUEST)) begin
               state_in = wfba_pkg::ST_SCAN;
            end
         end
         wfba_pkg::ST_SCAN: begin
            if (!rd_en && !pend_ff) begin
               state_in = wfba_pkg::ST_WRITE;
            end
         end
         wfba_pkg::ST_WRITE: begin
            state_in = wfba_pkg::ST_IDLE;
         end
         default: begin
            state_in = wfba_pkg::ST_IDLE;
         end
      endcase
   end

   // Saturating add shared by both totals; only one of them moves per request.
   assign sum_add = fit_found ?
                    ({1'b0, int_sum_ff} + (wfba_pkg::TOTAL_W + 1)'(fit_best_left)) :
                    ({1'b0, ext_sum_ff} + (wfba_pkg::TOTAL_W + 1)'(size_ff));
   assign sum_sat = sum_add[wfba_pkg::TOTAL_W] ? wfba_pkg::TOTAL_MAX :
                    sum_add[wfba_pkg::TOTAL_W-1:0];

   // Outputs and datapath register updates.
   always_comb begin
      busy             = 1'b1;
      blocks_in_use_in = blocks_in_use_ff;
      limit_in         = limit_ff;
      addr_in          = addr_ff;
      pend_in          = 1'b0;
      cmp_idx_in       = cmp_idx_ff;
      size_in          = size_ff;
      int_sum_in       = int_sum_ff;
      ext_sum_in       = ext_sum_ff;
      rsp_valid_in     = 1'b0;
      rsp_granted_in   = rsp_granted_ff;
      rsp_chosen_in    = rsp_chosen_ff;
      fit_clear        = 1'b0;
      tbl_wr_en        = load_hit;
      tbl_wr_addr      = IDX_W'(req_block_index);
      tbl_wr_data      = req_size_cut;
      if (csr_wr_en) begin
         blocks_in_use_in = csr_wr_data;
      end
      case (state_ff)
         wfba_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (accept) begin
               limit_in  = limit_clamped;
               addr_in   = '0;
               size_in   = req_size_cut;
               fit_clear = 1'b1;
            end
         end
         wfba_pkg::ST_SCAN: begin
            pend_in = rd_en;
            if (rd_en) begin
               addr_in    = addr_ff + CNT_W'(1);
               cmp_idx_in = addr_ff[IDX_W-1:0];
            end
         end
         wfba_pkg::ST_WRITE: begin
            tbl_wr_en      = fit_found;
            tbl_wr_addr    = fit_best_idx;
            tbl_wr_data    = fit_best_left;
            rsp_valid_in   = 1'b1;
            rsp_granted_in = fit_found;
            rsp_chosen_in  = fit_found ? wfba_pkg::REQ_IDX_W'(fit_best_idx) : '0;
            if (fit_found) begin
               int_sum_in = sum_sat;
            end else begin
               ext_sum_in = sum_sat;
            end
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= wfba_pkg::ST_IDLE;
         blocks_in_use_ff <= '0;
         pend_ff          <= 1'b0;
         int_sum_ff       <= '0;
         ext_sum_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         blocks_in_use_ff <= blocks_in_use_in;
         pend_ff          <= pend_in;
         int_sum_ff       <= int_sum_in;
         ext_sum_ff       <= ext_sum_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      limit_ff       <= limit_in;
      addr_ff        <= addr_in;
      cmp_idx_ff     <= cmp_idx_in;
      size_ff        <= size_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_chosen_ff  <= rsp_chosen_in;
   end

   wfba_table #(
      .DEPTH (NUM_BLOCKS),
      .WIDTH (SIZE_BITS),
      .AW    (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (rd_en),
      .rd_addr (addr_ff[IDX_W-1:0]),
      .rd_data (tbl_rd_data)
   );

   wfba_fit_unit #(
      .SIZE_BITS (SIZE_BITS),
      .IDX_W     (IDX_W)
   ) u_fit (
      .clock     (clock),
      .reset     (reset),
      .clear     (fit_clear),
      .valid     (pend_ff),
      .free_size (tbl_rd_data),
      .entry_idx (cmp_idx_ff),
      .req_size  (size_ff),
      .found     (fit_found),
      .best_idx  (fit_best_idx),
      .best_left (fit_best_left)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_granted        = rsp_granted_ff;
   assign rsp_chosen_block   = rsp_chosen_ff;
   assign rsp_internal_total = int_sum_ff;
   assign rsp_external_total = ext_sum_ff;

`ifndef SYNTH
   // A response word only ever follows the write-back cycle of a request.
   a_rsp_after_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == wfba_pkg::ST_WRITE))
      else $error("response strobe without a preceding write-back");

   // A refused request always reports block zero.
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_granted) |-> (rsp_chosen_block == '0))
      else $error("refused request reports a nonzero block");

   // The scan address never runs past the clamped entry count.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wfba_pkg::ST_SCAN) |-> (addr_ff <= limit_ff))
      else $error("scan address beyond the searched range");
`endif

endmodule

// ----- tb/sv/worst_fit_block_allocator_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for worst_fit_block_allocator: a queue-fed driver, a result monitor
// and an in-bench model of the free-size table and both fragmentation totals.
// Depends on wfba_pkg and the allocator RTL.
module worst_fit_block_allocator_test;

   localparam int NUM_BLOCKS    = 16;
   localparam int SIZE_BITS     = 16;
   localparam int SETTLE_CYCLES = 24;
   localparam int PHASE_WORDS   = 192;

   typedef enum logic [1:0] {
      WORD_ITEM,
      WORD_CSR,
      WORD_DRAIN
   } word_kind_type;

   typedef struct {
      word_kind_type                       kind;
      logic [wfba_pkg::MODE_W-1:0]         mode;
      logic [wfba_pkg::REQ_IDX_W-1:0]      index;
      logic [wfba_pkg::REQ_SIZE_W-1:0]     size;
      logic [wfba_pkg::CSR_W-1:0]          csr_value;
      int                                  gap;
   } stim_word_type;

   typedef struct packed {
      logic                                granted;
      logic [wfba_pkg::REQ_IDX_W-1:0]      chosen;
      logic [wfba_pkg::TOTAL_W-1:0]        internal_total;
      logic [wfba_pkg::TOTAL_W-1:0]        external_total;
   } alloc_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic [wfba_pkg::MODE_W-1:0]         req_mode = wfba_pkg::MODE_LOAD;
   logic [wfba_pkg::REQ_IDX_W-1:0]      req_block_index = '0;
   logic [wfba_pkg::REQ_SIZE_W-1:0]     req_size = '0;
   logic                                rsp_valid;
   logic                                rsp_granted;
   logic [wfba_pkg::REQ_IDX_W-1:0]      rsp_chosen_block;
   logic [wfba_pkg::TOTAL_W-1:0]        rsp_internal_total;
   logic [wfba_pkg::TOTAL_W-1:0]        rsp_external_total;
   logic                                csr_wr_en = 1'b0;
   logic [wfba_pkg::CSR_W-1:0]          csr_wr_data = '0;

   // Model state: table, totals and the searched-entry count.
   logic [SIZE_BITS-1:0]                free_tab [NUM_BLOCKS] = '{default: '0};
   logic [wfba_pkg::TOTAL_W-1:0]        frag_internal = '0;
   logic [wfba_pkg::TOTAL_W-1:0]        frag_external = '0;
   logic [wfba_pkg::CSR_W-1:0]          blocks_cfg = '0;

   stim_word_type                       pending_words [$];
   alloc_result_type                    alloc_due [$];
   int                                  requests_sent = 0;
   int                                  answers_seen = 0;
   int                                  since_accept = 0;
   int                                  idle_run = 0;
   int                                  mismatches = 0;
   int                                  calm_left = 0;

   worst_fit_block_allocator #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_mode           (req_mode),
      .req_block_index    (req_block_index),
      .req_size           (req_size),
      .rsp_valid          (rsp_valid),
      .rsp_granted        (rsp_granted),
      .rsp_chosen_block   (rsp_chosen_block),
      .rsp_internal_total (rsp_internal_total),
      .rsp_external_total (rsp_external_total),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic logic [wfba_pkg::TOTAL_W-1:0] sat_sum(
      input logic [wfba_pkg::TOTAL_W-1:0] total,
      input logic [SIZE_BITS-1:0]         add);
      logic [wfba_pkg::TOTAL_W:0] wide;
      wide = {1'b0, total} + (wfba_pkg::TOTAL_W + 1)'(add);
      return wide[wfba_pkg::TOTAL_W] ? wfba_pkg::TOTAL_MAX : wide[wfba_pkg::TOTAL_W-1:0];
   endfunction

   // Applies one accepted word to the model; returns 1 when it yields a result word.
   function automatic bit predict_allocation(input logic [wfba_pkg::MODE_W-1:0] mode,
                                             input logic [wfba_pkg::REQ_IDX_W-1:0] idx,
                                             input logic [wfba_pkg::REQ_SIZE_W-1:0] size,
                                             output alloc_result_type res);
      int                             lim;
      bit                             found;
      logic [wfba_pkg::REQ_IDX_W-1:0] best;
      logic [SIZE_BITS-1:0]           best_left;
      found = 1'b0;
      best = '0;
      best_left = '0;
      res = '0;
      if (mode == wfba_pkg::MODE_LOAD) begin
         if (idx < NUM_BLOCKS) free_tab[idx] = size;
         return 1'b0;
      end
      lim = (blocks_cfg > NUM_BLOCKS) ? NUM_BLOCKS : int'(blocks_cfg);
      for (int j = 0; j < lim; j++) begin
         // A later entry only wins on a strictly larger leftover.
         if (free_tab[j] >= size && (!found || free_tab[j] - size > best_left)) begin
            found = 1'b1;
            best = wfba_pkg::REQ_IDX_W'(j);
            best_left = free_tab[j] - size;
         end
      end
      if (found) begin
         free_tab[best] = best_left;
         frag_internal = sat_sum(frag_internal, best_left);
      end else begin
         frag_external = sat_sum(frag_external, size);
         best = '0;
      end
      res.granted = found;
      res.chosen = best;
      res.internal_total = frag_internal;
      res.external_total = frag_external;
      return 1'b1;
   endfunction

   task automatic note_mismatch(input string what);
      mismatches++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   task automatic add_word(input logic [wfba_pkg::MODE_W-1:0] mode,
                           input logic [wfba_pkg::REQ_IDX_W-1:0] idx,
                           input logic [wfba_pkg::REQ_SIZE_W-1:0] size, input bit may_idle);
      stim_word_type w;
      w.kind = WORD_ITEM;
      w.mode = mode;
      w.index = idx;
      w.size = size;
      w.csr_value = '0;
      // Occasional runs of back-to-back words with no idle cycles at all.
      if (!may_idle || calm_left > 0) begin
         w.gap = 0;
         if (calm_left > 0) calm_left--;
      end else begin
         w.gap = int'($urandom_range(0, 12));
         if ($urandom_range(0, 49) == 0) calm_left = 40;
      end
      pending_words.push_back(w);
   endtask

   task automatic add_control(input word_kind_type kind,
                              input logic [wfba_pkg::CSR_W-1:0] value);
      stim_word_type w;
      w.kind = kind;
      w.mode = wfba_pkg::MODE_LOAD;
      w.index = '0;
      w.size = '0;
      w.csr_value = value;
      w.gap = 0;
      pending_words.push_back(w);
   endtask

   task automatic add_random_phase(input logic [wfba_pkg::CSR_W-1:0] count);
      int                              lim;
      logic [wfba_pkg::REQ_IDX_W-1:0]  idx;
      logic [wfba_pkg::REQ_SIZE_W-1:0] size;
      lim = (count > NUM_BLOCKS) ? NUM_BLOCKS : int'(count);
      add_control(WORD_CSR, count);
      for (int i = 0; i < PHASE_WORDS; i++) begin
         if (i == PHASE_WORDS / 2) add_control(WORD_DRAIN, '0);
         idx = wfba_pkg::REQ_IDX_W'($urandom_range(0, 15));
         if ($urandom_range(0, 9) < 4) begin
            // Keep the searched entries refilled so grants stay common.
            if (lim > 0 && $urandom_range(0, 1) == 1)
               idx = wfba_pkg::REQ_IDX_W'($urandom_range(0, lim - 1));
            case ($urandom_range(0, 7))
               0: size = '0;
               1: size = '1;
               2, 3: size = wfba_pkg::REQ_SIZE_W'($urandom_range(0, 255));
               4: size = 16'd4096;
               default: size = wfba_pkg::REQ_SIZE_W'($urandom);
            endcase
            add_word(wfba_pkg::MODE_LOAD, idx, size, 1'b1);
         end else begin
            case ($urandom_range(0, 7))
               0: size = '0;
               1: size = '1;
               2, 3, 4: size = wfba_pkg::REQ_SIZE_W'($urandom_range(0, 255));
               5: size = wfba_pkg::REQ_SIZE_W'($urandom_range(0, 4096));
               default: size = wfba_pkg::REQ_SIZE_W'($urandom);
            endcase
            add_word(wfba_pkg::MODE_REQUEST, idx, size, 1'b1);
         end
      end
   endtask

   // Driver: presents queued words, pulses register writes when the block is quiet.
   always @(posedge clock) begin
      stim_word_type    head;
      alloc_result_type due;
      logic             present;
      logic             csr_pulse;
      int               elapsed;
      present = start;
      csr_pulse = 1'b0;
      elapsed = since_accept;
      if (reset) begin
         start <= 1'b0;
         csr_wr_en <= 1'b0;
         since_accept <= 0;
         idle_run <= 0;
      end else begin
         if (start && !busy) begin
            if (predict_allocation(req_mode, req_block_index, req_size, due)) begin
               alloc_due.push_back(due);
               requests_sent <= requests_sent + 1;
            end
            present = 1'b0;
            elapsed = 0;
         end
         if (!present && pending_words.size() != 0) begin
            head = pending_words[0];
            case (head.kind)
               WORD_ITEM: if (elapsed >= head.gap) begin
                  present = 1'b1;
                  req_mode <= head.mode;
                  req_block_index <= head.index;
                  req_size <= head.size;
                  void'(pending_words.pop_front());
               end
               WORD_CSR: if (!start && idle_run >= SETTLE_CYCLES) begin
                  csr_pulse = 1'b1;
                  csr_wr_data <= head.csr_value;
                  blocks_cfg = head.csr_value;
                  void'(pending_words.pop_front());
               end
               default: if (!start && idle_run >= 1) begin
                  void'(pending_words.pop_front());
               end
            endcase
         end
         start <= present;
         csr_wr_en <= csr_pulse;
         since_accept <= elapsed + 1;
         idle_run <= (!start && !busy && requests_sent == answers_seen) ? idle_run + 1 : 0;
      end
   end

   // Monitor: every strobed result word is checked against the oldest prediction.
   always @(posedge clock) begin
      alloc_result_type want;
      if (!reset && rsp_valid) begin
         answers_seen <= answers_seen + 1;
         if (alloc_due.size() == 0) begin
            note_mismatch("result word with no request outstanding");
         end else begin
            want = alloc_due.pop_front();
            if (rsp_granted !== want.granted)
               note_mismatch($sformatf("granted %0b, expected %0b",
                                       rsp_granted, want.granted));
            if (rsp_chosen_block !== want.chosen)
               note_mismatch($sformatf("chosen_block %0d, expected %0d",
                                       rsp_chosen_block, want.chosen));
            if (rsp_internal_total !== want.internal_total)
               note_mismatch($sformatf("internal_total %0d, expected %0d",
                                       rsp_internal_total, want.internal_total));
            if (rsp_external_total !== want.external_total)
               note_mismatch($sformatf("external_total %0d, expected %0d",
                                       rsp_external_total, want.external_total));
         end
      end
   end

   initial begin
      #40ms;
      $display("[worst_fit_block_allocator] ERROR");
      $finish;
   end

   initial begin
      logic [SIZE_BITS-1:0] table_init [NUM_BLOCKS];
      table_init = '{16'd0, 16'd65535, 16'd1000, 16'd65535, 16'd7, 16'd12345, 16'd300,
                     16'd40000, 16'd1, 16'd2, 16'd65534, 16'd513, 16'd8191, 16'd256,
                     16'd32768, 16'd99};

      // With no entries searched, every request is refused.
      add_word(wfba_pkg::MODE_REQUEST, 4'd0, 16'd100, 1'b1);
      add_word(wfba_pkg::MODE_REQUEST, 4'd15, 16'd65535, 1'b1);
      for (int i = 0; i < NUM_BLOCKS; i++)
         add_word(wfba_pkg::MODE_LOAD, wfba_pkg::REQ_IDX_W'(i), table_init[i], 1'b1);
      add_control(WORD_CSR, 5'd16);
      // Two entries tie at the maximum: the lower index wins while both still tie.
      add_word(wfba_pkg::MODE_REQUEST, 4'd9, 16'd0, 1'b1);
      add_word(wfba_pkg::MODE_REQUEST, 4'd0, 16'd65535, 1'b1);
      add_word(wfba_pkg::MODE_REQUEST, 4'd0, 16'd65535, 1'b1);
      add_word(wfba_pkg::MODE_REQUEST, 4'd0, 16'd65535, 1'b1);
      // A count above the table size searches the whole table.
      add_control(WORD_CSR, 5'd31);
      add_word(wfba_pkg::MODE_REQUEST, 4'd3, 16'd1, 1'b1);
      // An exact fit into an empty entry leaves zero and is still a grant.
      add_control(WORD_CSR, 5'd1);
      add_word(wfba_pkg::MODE_REQUEST, 4'd0, 16'd0, 1'b1);

      add_random_phase(5'd16);
      add_random_phase(5'd1);
      add_random_phase(5'd31);
      add_random_phase(5'd5);
      add_random_phase(5'd0);
      add_random_phase(5'd17);
      add_random_phase(wfba_pkg::CSR_W'($urandom_range(2, 15)));
      add_random_phase(5'd16);
      add_random_phase(5'd16);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_words.size() != 0 || start || requests_sent != answers_seen);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (alloc_due.size() != 0)
         note_mismatch($sformatf("%0d result words never arrived", alloc_due.size()));
      if (mismatches == 0) begin
         $display("[worst_fit_block_allocator] OK");
      end else begin
         $display("[worst_fit_block_allocator] ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/wfba_pkg.sv
rtl/core/wfba_table.sv
rtl/core/wfba_fit_unit.sv
rtl/core/worst_fit_block_allocator.sv
tb/sv/worst_fit_block_allocator_test.sv
